>>> hw/rtl/tcgr_pkg.sv
package tcgr_pkg;

	// Default geometry of the panel and the font store
	localparam int SCREEN_WIDTH_DEF    = 128;
	localparam int SCREEN_HEIGHT_DEF   = 64;
	localparam int FONT_BYTES_DEF      = 2048;
	localparam int MAX_GLYPH_WIDTH_DEF = 8;

	// Fixed field widths
	localparam int CMD_W     = 2;
	localparam int FADDR_W   = 11;
	localparam int BYTE_W    = 8;
	localparam int COORD_W   = 8;
	localparam int PIX_W     = 10;
	localparam int GEOM_W    = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 4;
	localparam int PROD_W    = 12;

	// Tallest glyph column drawn, in rows minus one
	localparam logic [GEOM_W-1:0] MAX_ROWS = 4'd8;

	// Commands
	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PUT   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SET   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

	// Character codes with special handling
	localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'd10;
	localparam logic [BYTE_W-1:0] CH_SPACE   = 8'd32;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR     = 2'd3;

	// Register reset values
	localparam logic [GEOM_W-1:0] GLYPH_WIDTH_RST  = 4'd5;
	localparam logic [GEOM_W-1:0] GLYPH_HEIGHT_RST = 4'd7;
	localparam logic              FG_COLOR_RST     = 1'b1;
	localparam logic              BG_COLOR_RST     = 1'b0;

	// Drawing style handed to the column formatter
	typedef struct packed {
		logic [GEOM_W-1:0] height;
		logic              fg;
		logic              bg;
	} tcgr_style_t;

endpackage

>>> hw/rtl/tcgr_if.sv
interface tcgr_req_if;
	logic                           valid;
	logic                           ready;
	logic [tcgr_pkg::CMD_W-1:0]     cmd;
	logic [tcgr_pkg::FADDR_W-1:0]   font_addr;
	logic [tcgr_pkg::BYTE_W-1:0]    font_byte;
	logic [tcgr_pkg::BYTE_W-1:0]    char_code;
	logic [tcgr_pkg::COORD_W-1:0]   text_col;
	logic [tcgr_pkg::COORD_W-1:0]   text_row;

	modport source (output valid, cmd, font_addr, font_byte, char_code, text_col, text_row,
		input ready);
	modport sink (input valid, cmd, font_addr, font_byte, char_code, text_col, text_row,
		output ready);
endinterface

interface tcgr_res_if;
	logic                           valid;
	logic                           ready;
	logic [tcgr_pkg::COORD_W-1:0]   pix_x;
	logic [tcgr_pkg::COORD_W-1:0]   pix_y;
	logic [tcgr_pkg::PIX_W-1:0]     pixels;
	logic [tcgr_pkg::PIX_W-1:0]     write_mask;
	logic                           last;

	modport source (output valid, pix_x, pix_y, pixels, write_mask, last, input ready);
	modport sink (input valid, pix_x, pix_y, pixels, write_mask, last, output ready);
endinterface

interface tcgr_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [tcgr_pkg::CFG_IDX_W-1:0]   index;
	logic [tcgr_pkg::CFG_DAT_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/tcgr_ram.sv
module tcgr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

>>> hw/rtl/tcgr_col_fmt.sv
module tcgr_col_fmt (
	input  logic [tcgr_pkg::BYTE_W-1:0] col,
	input  tcgr_pkg::tcgr_style_t       style,
	output logic [tcgr_pkg::PIX_W-1:0]  pixels,
	output logic [tcgr_pkg::PIX_W-1:0]  write_mask
);
	import tcgr_pkg::*;

	// A ninth glyph row reads above the font byte and is always clear
	logic [BYTE_W:0] col_ext;

	assign col_ext = {1'b0, col};

	// Top row is always background; glyph rows 0..height sit one below it
	always_comb begin
		pixels        = '0;
		write_mask    = '0;
		pixels[0]     = style.bg;
		write_mask[0] = 1'b1;
		for (int j = 0; j <= int'(MAX_ROWS); j++) begin
			if (GEOM_W'(j) <= style.height) begin
				pixels[j+1]     = col_ext[j] ? style.fg : style.bg;
				write_mask[j+1] = col_ext[j] | (style.fg != style.bg);
			end
		end
	end
endmodule

>>> hw/rtl/text_cursor_glyph_renderer_unit.sv
// Text cursor glyph renderer. Commands arrive on req: load one font byte,
// put a character, set the cursor in character cells, or clear the cursor.
// A drawn character leaves on res as width+2 column writes, one per cycle
// while res is ready, the last one flagged. Load, set, clear and a consumed
// newline or space complete on acceptance, with req staying ready. A drawn
// character first forms the font index, then fetches its columns one at a
// time out of the single read port of the font RAM, whose read is registered,
// before req is ready again; the final column may still wait in the
// output register while the next request is taken. The font RAM has no
// clearing pass; entries read before they are loaded return unknown data.
// Configuration writes are taken every cycle and belong only to idle time.
module text_cursor_glyph_renderer_unit #(
	parameter int SCREEN_WIDTH    = tcgr_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT   = tcgr_pkg::SCREEN_HEIGHT_DEF,
	parameter int FONT_BYTES      = tcgr_pkg::FONT_BYTES_DEF,
	parameter int MAX_GLYPH_WIDTH = tcgr_pkg::MAX_GLYPH_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	tcgr_cfg_if.sink    cfg,
	tcgr_req_if.sink    req,
	tcgr_res_if.source  res
);
	import tcgr_pkg::*;

	localparam int AW = $clog2(FONT_BYTES);
	localparam int IDX_W = GEOM_W + 1;

	// Sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_BASE = 2'd1;
	localparam logic [1:0] ST_DRAW = 2'd2;

	// Configuration registers
	logic [GEOM_W-1:0] glyph_width_q;
	logic [GEOM_W-1:0] glyph_height_q;
	logic              fg_color_q;
	logic              bg_color_q;

	// Cursor and sequencer
	logic [COORD_W-1:0] cursor_x_q;
	logic [COORD_W-1:0] cursor_y_q;
	logic [1:0]         state_q;
	logic [IDX_W-1:0]   idx_q;
	logic               fetch_q;
	logic               valid_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               res_valid_q;

	// Payload registers
	logic [PROD_W-1:0]  prod_q;
	logic [AW-1:0]      ptr_q;
	logic [COORD_W-1:0] org_x_q;
	logic [COORD_W-1:0] org_y_q;
	logic [COORD_W-1:0] pix_x_q;
	logic [COORD_W-1:0] pix_y_q;
	logic [PIX_W-1:0]   pixels_q;
	logic [PIX_W-1:0]   mask_q;
	logic               last_q;

	// Effective geometry
	logic [GEOM_W-1:0]  w;
	logic [GEOM_W-1:0]  h;
	logic [IDX_W-1:0]   wp1;
	logic [GEOM_W-1:0]  hp1;

	logic               accept;
	logic               wrap;
	logic               is_nl;
	logic               is_sp;
	logic               consumed;
	logic               visible;
	logic [COORD_W-1:0] line_y;
	logic [COORD_W-1:0] x1;
	logic [COORD_W-1:0] y1;
	logic [COORD_W-1:0] set_x;
	logic [COORD_W-1:0] set_y;
	logic [AW-1:0]      base;
	logic               issue;
	logic               issue_last;
	logic               move_s1;
	logic               rd_en;
	logic               font_we;
	logic [BYTE_W-1:0]  rdata;
	logic [BYTE_W-1:0]  col_s1;
	logic [PIX_W-1:0]   fmt_pixels;
	logic [PIX_W-1:0]   fmt_mask;
	logic [PROD_W-1:0]  addr_ext;
	tcgr_style_t        style;

	assign w   = ({1'b0, glyph_width_q} > (GEOM_W+1)'(MAX_GLYPH_WIDTH)) ?
		GEOM_W'(MAX_GLYPH_WIDTH) : glyph_width_q;
	assign h   = (glyph_height_q > MAX_ROWS) ? MAX_ROWS : glyph_height_q;
	assign wp1 = {1'b0, w} + IDX_W'(1);
	assign hp1 = h + GEOM_W'(1);

	// Config port: always ready
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_width_q  <= GLYPH_WIDTH_RST;
			glyph_height_q <= GLYPH_HEIGHT_RST;
			fg_color_q     <= FG_COLOR_RST;
			bg_color_q     <= BG_COLOR_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_GLYPH_WIDTH:  glyph_width_q  <= cfg.data[GEOM_W-1:0];
				REG_GLYPH_HEIGHT: glyph_height_q <= cfg.data[GEOM_W-1:0];
				REG_FG_COLOR:     fg_color_q     <= cfg.data[0];
				REG_BG_COLOR:     bg_color_q     <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Take a request only between characters
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;

	// Line wrap and newline decisions on the current cursor
	assign wrap     = {1'b0, cursor_x_q} >=
		((COORD_W+1)'(SCREEN_WIDTH) - {{(COORD_W+1-GEOM_W){1'b0}}, w});
	assign is_nl    = (req.char_code == CH_NEWLINE);
	assign is_sp    = (req.char_code == CH_SPACE);
	assign line_y   = cursor_y_q + {{(COORD_W-GEOM_W){1'b0}}, hp1};
	assign x1       = (wrap || is_nl) ? '0 : cursor_x_q;
	assign y1       = (wrap || is_nl) ? line_y : cursor_y_q;
	assign consumed = wrap ? (is_sp || is_nl) : is_nl;
	assign visible  = {1'b0, y1} < (COORD_W+1)'(SCREEN_HEIGHT);

	// Cell position to pixels, wrapping at 8 bits
	always_comb begin
		logic [COORD_W+IDX_W-1:0]  px;
		logic [COORD_W+GEOM_W-1:0] py;
		px    = (COORD_W+IDX_W)'(req.text_col) * (COORD_W+IDX_W)'(wp1);
		py    = (COORD_W+GEOM_W)'(req.text_row) * (COORD_W+GEOM_W)'(hp1);
		set_x = px[COORD_W-1:0];
		set_y = py[COORD_W-1:0];
	end

	// Font load: drop addresses beyond the store
	assign addr_ext = {{(PROD_W-FADDR_W){1'b0}}, req.font_addr};
	assign font_we  = accept && (req.cmd == CMD_LOAD) &&
		({1'b0, addr_ext} < (PROD_W+1)'(FONT_BYTES));

	// Reduce char_code*width into the store; the quotient stays below 16
	always_comb begin
		logic [PROD_W+4:0] r;
		r = {5'd0, prod_q};
		for (int k = 3; k >= 0; k--) begin
			if (r >= ((PROD_W+5)'(FONT_BYTES) << k)) begin
				r = r - ((PROD_W+5)'(FONT_BYTES) << k);
			end
		end
		base = r[AW-1:0];
	end

	// Column issue: a read goes out only when stage 1 will be free to catch it
	assign move_s1    = valid_s1 && (!res_valid_q || res.ready);
	assign issue      = (state_q == ST_DRAW) && fetch_q && (!valid_s1 || move_s1);
	assign issue_last = (idx_q == wp1);
	assign rd_en      = issue && (idx_q != '0) && !issue_last;

	tcgr_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (FONT_BYTES)
	) u_font_ram (
		.clk   (clk),
		.we    (font_we),
		.waddr (addr_ext[AW-1:0]),
		.wdata (req.font_byte),
		.re    (rd_en),
		.raddr (ptr_q),
		.rdata (rdata)
	);

	// Blank edge columns, font byte elsewhere
	assign col_s1 = ((idx_s1 == '0) || (idx_s1 == wp1)) ? '0 : rdata;
	assign style  = '{height: h, fg: fg_color_q, bg: bg_color_q};

	tcgr_col_fmt u_col_fmt (
		.col        (col_s1),
		.style      (style),
		.pixels     (fmt_pixels),
		.write_mask (fmt_mask)
	);

	// Sequencer, cursor and stage-1 / output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cursor_x_q  <= '0;
			cursor_y_q  <= '0;
			idx_q       <= '0;
			fetch_q     <= 1'b0;
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (req.cmd)
							CMD_SET: begin
								cursor_x_q <= set_x;
								cursor_y_q <= set_y;
							end
							CMD_CLEAR: begin
								cursor_x_q <= '0;
								cursor_y_q <= '0;
							end
							CMD_PUT: begin
								if (consumed) begin
									cursor_x_q <= x1;
									cursor_y_q <= y1;
								end else begin
									// Advance now; the draw works from its own origin
									cursor_x_q <= x1 + {{(COORD_W-IDX_W){1'b0}}, wp1};
									cursor_y_q <= y1;
									if (visible) begin
										state_q <= ST_BASE;
									end
								end
							end
							default: ;
						endcase
					end
				end
				ST_BASE: begin
					idx_q   <= '0;
					fetch_q <= 1'b1;
					state_q <= ST_DRAW;
				end
				ST_DRAW: begin
					if (issue) begin
						idx_q <= idx_q + IDX_W'(1);
						if (issue_last) begin
							fetch_q <= 1'b0;
						end
					end
					if (!fetch_q && (!valid_s1 || move_s1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (move_s1) begin
				valid_s1 <= 1'b0;
			end

			if (move_s1) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept && (req.cmd == CMD_PUT)) begin
			prod_q  <= PROD_W'(req.char_code) * PROD_W'(w);
			org_x_q <= x1;
			org_y_q <= y1;
		end
		if (state_q == ST_BASE) begin
			ptr_q <= base;
		end else if (rd_en) begin
			ptr_q <= (ptr_q == AW'(FONT_BYTES - 1)) ? '0 : ptr_q + AW'(1);
		end
		if (issue) begin
			idx_s1 <= idx_q;
		end
		if (move_s1) begin
			pix_x_q  <= org_x_q + {{(COORD_W-IDX_W){1'b0}}, idx_s1};
			pix_y_q  <= org_y_q;
			pixels_q <= fmt_pixels;
			mask_q   <= fmt_mask;
			last_q   <= (idx_s1 == wp1);
		end
	end

	assign res.valid      = res_valid_q;
	assign res.pix_x      = pix_x_q;
	assign res.pix_y      = pix_y_q;
	assign res.pixels     = pixels_q;
	assign res.write_mask = mask_q;
	assign res.last       = last_q;

endmodule

>>> hw/rtl/tcgr_checker.sv
module tcgr_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic [tcgr_pkg::CMD_W-1:0]   req_cmd,
	input logic                         res_valid,
	input logic                         res_ready,
	input logic [tcgr_pkg::COORD_W-1:0] res_pix_x,
	input logic [tcgr_pkg::COORD_W-1:0] res_pix_y,
	input logic [tcgr_pkg::PIX_W-1:0]   res_pixels,
	input logic [tcgr_pkg::PIX_W-1:0]   res_mask,
	input logic                         res_last
);
	import tcgr_pkg::*;

	// A stalled column write holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_pix_x) &&
		$stable(res_pix_y) && $stable(res_pixels) && $stable(res_mask) && $stable(res_last))
		else $error("column write changed while stalled");

	// Mid-character, no new request is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_last |-> !req_ready)
		else $error("request taken before character finished");

	// Columns of one character advance by one
	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !res_last |=>
		!res_valid || (res_pix_x == $past(res_pix_x) + 8'd1 && res_pix_y == $past(res_pix_y)))
		else $error("column position out of sequence");

	// Only a character request starts column writes
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_cmd != CMD_PUT |=> !$rose(res_valid))
		else $error("column write without character request");
endmodule

bind text_cursor_glyph_renderer_unit tcgr_checker u_tcgr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.req_cmd    (req.cmd),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.res_pix_x  (res.pix_x),
	.res_pix_y  (res.pix_y),
	.res_pixels (res.pixels),
	.res_mask   (res.write_mask),
	.res_last   (res.last)
);
